### rtl/dstm_pkg.sv
// ----------------------------------------------------------------------------
// Duration text to minutes: shared definitions
// Result status codes, character codes and the constant multipliers used by
// the duration parser.
// ----------------------------------------------------------------------------
package dstm_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_t;

  localparam int MINUTES_W = 31;
  localparam logic [MINUTES_W-1:0] MINUTES_MAX = '1;

  localparam int MIN_PER_DAY  = 1440;
  localparam int MIN_PER_HOUR = 60;
  localparam int DEC_BASE     = 10;

  // Part index of the third colon-separated field.
  localparam logic [1:0] LAST_PART = 2'd2;

  localparam logic [3:0] POS_MAX = 4'd15;

  localparam byte_t CH_ZERO  = "0";
  localparam byte_t CH_NINE  = "9";
  localparam byte_t CH_COLON = ":";
  localparam byte_t CH_DASH  = "-";
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;

  localparam int WORD_LEN = 9;
  localparam byte_t WORD_UPPER [WORD_LEN] = '{"U", "N", "L", "I", "M", "I", "T", "E", "D"};
  localparam byte_t WORD_LOWER [WORD_LEN] = '{"u", "n", "l", "i", "m", "i", "t", "e", "d"};

endpackage

### rtl/duration_string_to_minutes.sv
// ----------------------------------------------------------------------------
// Duration text to minutes
// Parses a batch-job time limit text (M, M:S, H:M:S, D-H, D-H:M, D-H:M:S,
// UNLIMITED) one character per item and returns whole minutes, rounded up.
// ----------------------------------------------------------------------------
// The block takes one character item in every clock cycle while in_tready
// is high, with no gaps needed between texts. A text ends with the item
// that has tlast set, or with an item that has tuser set (that item carries
// no character). Once its final item is accepted, a text's result passes
// through the input register, where the parser state takes the character,
// the snapshot, the product stage (constant day and hour multiplications)
// and the final saturating sum into the output register. Characters that end
// no text keep flowing while a result waits on the output, so input is only
// held off when every stage behind the parser holds a result.
module duration_string_to_minutes #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  input  logic        in_tuser,   // empty_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [30:0] minutes, [32:31] status, rest zero
);
  import dstm_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + 4;
  localparam int DW = VW + 11;
  localparam int HW = VW + 6;
  localparam int SW = VW + 2;
  localparam int CW = (SW > MINUTES_W) ? SW : MINUTES_W;
  localparam logic [VW-1:0] VMAX = '1;

  // Input register.
  logic        a_v_r;
  byte_t       a_char_r;
  logic        a_last_r;
  logic        a_empty_r;

  // Parser state.
  logic [VW-1:0] day_r, day_nxt, day_b;
  logic [VW-1:0] pv_r [3];
  logic [VW-1:0] pv_nxt [3];
  logic [VW-1:0] pv_b [3];
  logic [1:0]    pidx_r, pidx_nxt, pidx_b;
  logic          dig_r, dig_nxt, dig_b;
  logic          dash_r, dash_nxt, dash_b;
  logic          blank_r, blank_nxt, blank_b;
  logic          fmt_r, fmt_nxt, fmt_b;
  logic          ovr_r, ovr_nxt, ovr_b;
  logic [1:0]    wm_r, wm_nxt, wm_b;
  logic [3:0]    pos_r, pos_nxt, pos_b;

  // Snapshot of the state at the end of a text.
  logic          s_v_r;
  logic [VW-1:0] s_day_r;
  logic [VW-1:0] s_pv_r [3];
  logic [1:0]    s_pidx_r;
  logic          s_dig_r, s_dash_r, s_blank_r, s_fmt_r, s_ovr_r;
  logic [1:0]    s_wm_r;
  logic [3:0]    s_pos_r;

  // Product stage.
  logic          c_v_r;
  logic [VW-1:0] c_a_r, c_b_r, c_c_r;
  logic          c_inc_r, c_ov_r, c_inv_r;
  logic [VW-1:0] c_a_nxt, c_b_nxt, c_c_nxt;
  logic          c_inc_nxt, c_ov_nxt, c_inv_nxt;

  // Output register.
  logic                 out_v_r;
  logic [MINUTES_W-1:0] out_min_r, out_min_nxt;
  status_t              out_st_r, out_st_nxt;

  // Flow control.
  logic out_free, c_go, c_free, s_go, s_free, a_end, a_go;

  assign out_free  = !out_v_r || out_tready;
  assign c_go      = c_v_r && out_free;
  assign c_free    = !c_v_r || out_free;
  assign s_go      = s_v_r && c_free;
  assign s_free    = !s_v_r || c_free;
  assign a_end     = a_last_r || a_empty_r;
  assign a_go      = a_v_r && (!a_end || s_free);
  assign in_tready = !a_v_r || a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_tready) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_char_r  <= in_tdata;
      a_last_r  <= in_tlast;
      a_empty_r <= in_tuser;
    end
  end

  // State after taking the character in the input register.
  logic [3:0]    digit;
  logic [PW-1:0] acc;

  always_comb begin
    day_nxt   = day_r;
    pv_nxt    = pv_r;
    pidx_nxt  = pidx_r;
    dig_nxt   = dig_r;
    dash_nxt  = dash_r;
    blank_nxt = blank_r;
    fmt_nxt   = fmt_r;
    ovr_nxt   = ovr_r;
    wm_nxt    = wm_r;
    pos_nxt   = pos_r;
    digit     = 4'(a_char_r - CH_ZERO);
    acc       = PW'(pv_r[pidx_r]) * PW'(DEC_BASE) + PW'(digit);

    if (pos_r < 4'(WORD_LEN)) begin
      if (a_char_r != WORD_UPPER[pos_r]) wm_nxt[0] = 1'b0;
      if (a_char_r != WORD_LOWER[pos_r]) wm_nxt[1] = 1'b0;
    end else begin
      wm_nxt = 2'b00;
    end
    if (pos_r < POS_MAX) pos_nxt = pos_r + 4'd1;

    if (a_char_r inside {[CH_ZERO:CH_NINE]}) begin
      if (acc > PW'(VMAX)) begin
        pv_nxt[pidx_r] = VMAX;
        ovr_nxt        = 1'b1;
      end else begin
        pv_nxt[pidx_r] = acc[VW-1:0];
      end
      dig_nxt   = 1'b1;
      blank_nxt = 1'b0;
    end else if (a_char_r == CH_COLON) begin
      if (pidx_r >= LAST_PART || !dig_r) begin
        fmt_nxt = 1'b1;
      end else begin
        pidx_nxt = pidx_r + 2'd1;
        dig_nxt  = 1'b0;
      end
      blank_nxt = 1'b0;
    end else if (a_char_r == CH_DASH && !dash_r) begin
      dash_nxt = 1'b1;
      if (pidx_r != 2'd0 || !dig_r || fmt_r) begin
        fmt_nxt   = 1'b1;
        blank_nxt = 1'b0;
      end else begin
        day_nxt   = pv_r[0];
        pv_nxt[0] = '0;
        dig_nxt   = 1'b0;
        blank_nxt = 1'b1;
      end
    end else begin
      fmt_nxt = 1'b1;
      if (!(a_char_r inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) blank_nxt = 1'b0;
    end
  end

  // An empty item ends the text without a character.
  always_comb begin
    day_b   = a_empty_r ? day_r   : day_nxt;
    pv_b    = pv_nxt;
    if (a_empty_r) pv_b = pv_r;
    pidx_b  = a_empty_r ? pidx_r  : pidx_nxt;
    dig_b   = a_empty_r ? dig_r   : dig_nxt;
    dash_b  = a_empty_r ? dash_r  : dash_nxt;
    blank_b = a_empty_r ? blank_r : blank_nxt;
    fmt_b   = a_empty_r ? fmt_r   : fmt_nxt;
    ovr_b   = a_empty_r ? ovr_r   : ovr_nxt;
    wm_b    = a_empty_r ? wm_r    : wm_nxt;
    pos_b   = a_empty_r ? pos_r   : pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (a_go && a_end)) begin
      day_r   <= '0;
      pv_r    <= '{default: '0};
      pidx_r  <= '0;
      dig_r   <= 1'b0;
      dash_r  <= 1'b0;
      blank_r <= 1'b1;
      fmt_r   <= 1'b0;
      ovr_r   <= 1'b0;
      wm_r    <= 2'b11;
      pos_r   <= '0;
    end else if (a_go) begin
      day_r   <= day_nxt;
      pv_r    <= pv_nxt;
      pidx_r  <= pidx_nxt;
      dig_r   <= dig_nxt;
      dash_r  <= dash_nxt;
      blank_r <= blank_nxt;
      fmt_r   <= fmt_nxt;
      ovr_r   <= ovr_nxt;
      wm_r    <= wm_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (a_go && a_end) begin
      s_v_r <= 1'b1;
    end else if (s_go) begin
      s_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_end) begin
      s_day_r   <= day_b;
      s_pv_r    <= pv_b;
      s_pidx_r  <= pidx_b;
      s_dig_r   <= dig_b;
      s_dash_r  <= dash_b;
      s_blank_r <= blank_b;
      s_fmt_r   <= fmt_b;
      s_ovr_r   <= ovr_b;
      s_wm_r    <= wm_b;
      s_pos_r   <= pos_b;
    end
  end

  // Pick the terms of the final sum and form the saturated products.
  logic [DW-1:0] day_prod;
  logic [HW-1:0] hr_prod;
  logic [VW-1:0] day_sat, hr_sat;
  logic          day_ov, hr_ov, zero_case, three_parts, two_plus;

  always_comb begin
    day_prod    = DW'(s_day_r) * DW'(MIN_PER_DAY);
    hr_prod     = HW'(s_pv_r[0]) * HW'(MIN_PER_HOUR);
    day_ov      = day_prod > DW'(VMAX);
    hr_ov       = hr_prod > HW'(VMAX);
    day_sat     = day_ov ? VMAX : day_prod[VW-1:0];
    hr_sat      = hr_ov ? VMAX : hr_prod[VW-1:0];
    zero_case   = (s_pos_r == 4'd0) || (s_pos_r == 4'(WORD_LEN) && s_wm_r != 2'b00);
    three_parts = s_pidx_r == LAST_PART;
    two_plus    = s_pidx_r != 2'd0;

    c_a_nxt   = '0;
    c_b_nxt   = '0;
    c_c_nxt   = '0;
    c_inc_nxt = 1'b0;
    c_ov_nxt  = s_ovr_r;
    c_inv_nxt = 1'b0;

    if (zero_case) begin
      c_inv_nxt = 1'b0;
    end else if (s_dash_r && s_blank_r) begin
      c_a_nxt  = day_sat;
      c_ov_nxt = s_ovr_r || day_ov;
    end else if (s_fmt_r || !s_dig_r) begin
      c_inv_nxt = 1'b1;
    end else if (!s_dash_r) begin
      if (three_parts) begin
        c_b_nxt   = hr_sat;
        c_c_nxt   = s_pv_r[1];
        c_inc_nxt = s_pv_r[2] != '0;
        c_ov_nxt  = s_ovr_r || hr_ov;
      end else begin
        c_b_nxt   = s_pv_r[0];
        c_inc_nxt = two_plus && (s_pv_r[1] != '0);
      end
    end else begin
      c_a_nxt   = day_sat;
      c_b_nxt   = hr_sat;
      c_c_nxt   = two_plus ? s_pv_r[1] : '0;
      c_inc_nxt = three_parts && (s_pv_r[2] != '0);
      c_ov_nxt  = s_ovr_r || day_ov || hr_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_free) begin
      c_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      c_a_r   <= c_a_nxt;
      c_b_r   <= c_b_nxt;
      c_c_r   <= c_c_nxt;
      c_inc_r <= c_inc_nxt;
      c_ov_r  <= c_ov_nxt;
      c_inv_r <= c_inv_nxt;
    end
  end

  // Saturating sum of all terms: the operands are never negative, so
  // saturating the total gives the same value as saturating each step.
  logic [SW-1:0] sum;
  logic          sum_ov, clip;
  logic [VW-1:0] m_sat;
  logic [CW-1:0] m_ext;

  always_comb begin
    sum    = SW'(c_a_r) + SW'(c_b_r) + SW'(c_c_r) + SW'(c_inc_r);
    sum_ov = sum > SW'(VMAX);
    m_sat  = sum_ov ? VMAX : sum[VW-1:0];
    m_ext  = CW'(m_sat);
    clip   = m_ext > CW'(MINUTES_MAX);
    if (c_inv_r) begin
      out_min_nxt = '0;
      out_st_nxt  = ST_INVALID;
    end else begin
      out_min_nxt = clip ? MINUTES_MAX : m_ext[MINUTES_W-1:0];
      out_st_nxt  = (c_ov_r || sum_ov || clip) ? ST_TOO_LARGE : ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      out_min_r <= out_min_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_st_r, out_min_r};

  // A format error always reports zero minutes.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_st_r == ST_INVALID) |-> (out_min_r == '0))
    else $error("invalid result with nonzero minutes");

  // The end of a text always leaves a snapshot waiting for the product stage.
  a_end_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_end) |=> s_v_r)
    else $error("text end lost before the product stage");

  // Parser state is back to its start values after each text.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_end) |=> (pos_r == 4'd0 && pidx_r == 2'd0 && wm_r == 2'b11))
    else $error("parser state not cleared after text end");

  // A result never overwrites one that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("waiting result changed");

endmodule

### tb/duration_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duration text to minutes: result checker
// Watches both stream channels, parses every accepted character item with
// its own copy of the parser state and compares each result item, field by
// field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module duration_checker
  import dstm_pkg::*;
#(
  parameter int VALUE_WIDTH = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  input  logic        in_tuser,   // empty_text
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [30:0] minutes, [32:31] status, rest zero
  output int          fail_count,
  output int          pending
);

  localparam logic [63:0] FIELD_MAX  = (64'd1 << VALUE_WIDTH) - 64'd1;
  localparam logic [63:0] RESULT_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [MINUTES_W-1:0] minutes;
    status_t              status;
  } duration_t;

  duration_t limits_q[$];

  logic [63:0] day_total;
  logic [63:0] field_val [3];
  logic [1:0]  field_idx;
  logic        got_digit;
  logic        got_dash;
  logic        tail_blank;
  logic        form_bad;
  logic        saturated;
  logic [1:0]  word_live;
  logic [3:0]  char_count;

  function automatic void clear_parse();
    day_total  = '0;
    field_val  = '{default: '0};
    field_idx  = '0;
    got_digit  = 1'b0;
    got_dash   = 1'b0;
    tail_blank = 1'b1;
    form_bad   = 1'b0;
    saturated  = 1'b0;
    word_live  = 2'b11;
    char_count = '0;
  endfunction

  // Appends a predicted result behind the ones still waiting.
  function automatic void queue_result(input duration_t r);
    limits_q.insert(limits_q.size(), r);
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    if (a > FIELD_MAX || b > FIELD_MAX - a) begin
      saturated = 1'b1;
      return FIELD_MAX;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] sat_scale(input logic [63:0] a, input logic [63:0] k);
    if (k != 0 && a > FIELD_MAX / k) begin
      saturated = 1'b1;
      return FIELD_MAX;
    end
    return a * k;
  endfunction

  function automatic void absorb_char(input byte_t c);
    logic [63:0] d;
    int          slot;
    if (char_count < WORD_LEN) begin
      if (c != WORD_UPPER[char_count]) word_live[0] = 1'b0;
      if (c != WORD_LOWER[char_count]) word_live[1] = 1'b0;
    end else begin
      word_live = 2'b00;
    end
    if (char_count != POS_MAX) char_count++;

    if (c >= CH_ZERO && c <= CH_NINE) begin
      d    = 64'(c - CH_ZERO);
      slot = (field_idx > LAST_PART) ? LAST_PART : field_idx;
      if (field_val[slot] > (FIELD_MAX - d) / DEC_BASE) begin
        field_val[slot] = FIELD_MAX;
        saturated = 1'b1;
      end else begin
        field_val[slot] = field_val[slot] * DEC_BASE + d;
      end
      got_digit  = 1'b1;
      tail_blank = 1'b0;
    end else if (c == CH_COLON) begin
      if (field_idx >= LAST_PART || !got_digit) begin
        form_bad = 1'b1;
      end else begin
        field_idx++;
        got_digit = 1'b0;
      end
      tail_blank = 1'b0;
    end else if (c == CH_DASH && !got_dash) begin
      got_dash = 1'b1;
      if (field_idx != 0 || !got_digit || form_bad) begin
        form_bad   = 1'b1;
        tail_blank = 1'b0;
      end else begin
        day_total    = field_val[0];
        field_val[0] = '0;
        got_digit    = 1'b0;
        tail_blank   = 1'b1;
      end
    end else begin
      // Blanks after "D-" leave the day-only form possible.
      form_bad = 1'b1;
      if (!(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) tail_blank = 1'b0;
    end
  endfunction

  function automatic duration_t close_text();
    logic [63:0] m;
    logic [63:0] s;
    status_t     st;
    int          parts;
    duration_t   r;
    m  = '0;
    s  = '0;
    st = ST_VALID;
    if (char_count == 0 || (char_count == WORD_LEN && word_live != 2'b00)) begin
      m = '0;
    end else if (got_dash && tail_blank) begin
      m = sat_scale(day_total, MIN_PER_DAY);
    end else if (form_bad || !got_digit) begin
      st = ST_INVALID;
    end else begin
      parts = ((field_idx > LAST_PART) ? LAST_PART : field_idx) + 1;
      if (!got_dash) begin
        if (parts == 1) begin
          m = field_val[0];
        end else if (parts == 2) begin
          m = field_val[0];
          s = field_val[1];
        end else begin
          m = sat_sum(sat_scale(field_val[0], MIN_PER_HOUR), field_val[1]);
          s = field_val[2];
        end
      end else begin
        m = sat_sum(sat_scale(day_total, MIN_PER_DAY), sat_scale(field_val[0], MIN_PER_HOUR));
        if (parts >= 2) m = sat_sum(m, field_val[1]);
        if (parts == 3) s = field_val[2];
      end
      // Leftover seconds round the result up by one minute.
      if (s != 0) m = sat_sum(m, 64'd1);
    end
    if (st == ST_VALID) begin
      if (m > RESULT_MAX) begin
        m = RESULT_MAX;
        saturated = 1'b1;
      end
      if (saturated) st = ST_TOO_LARGE;
    end
    r.minutes = m[MINUTES_W-1:0];
    r.status  = st;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    duration_t want;
    if (!rst_n) begin
      clear_parse();
      limits_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (limits_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result minutes %0d status %0d", $realtime,
                     out_tdata[MINUTES_W-1:0], out_tdata[MINUTES_W+1:MINUTES_W]);
        end else begin
          want = limits_q.pop_front();
          if (out_tdata[MINUTES_W-1:0] !== want.minutes ||
              out_tdata[MINUTES_W+1:MINUTES_W] !== want.status ||
              out_tdata[39:MINUTES_W+2] !== '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected minutes %0d status %0d, got minutes %0d status %0d pad %h",
                       $realtime, want.minutes, want.status, out_tdata[MINUTES_W-1:0],
                       out_tdata[MINUTES_W+1:MINUTES_W], out_tdata[39:MINUTES_W+2]);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          // An empty item ends the text without adding a character.
          queue_result(close_text());
          clear_parse();
        end else begin
          absorb_char(in_tdata);
          if (in_tlast) begin
            queue_result(close_text());
            clear_parse();
          end
        end
      end
    end
    pending = limits_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duration text to minutes: testbench top
// Sends directed and random duration texts one character item at a time,
// with random gaps on the input and random stalls on the output, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import dstm_pkg::*;

  localparam int VALUE_WIDTH = 31;
  localparam int PERIOD      = 12;
  localparam int ITEM_TARGET = 950;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        in_tlast = 1'b0; // last_char
  logic        in_tuser = 1'b0; // empty_text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [30:0] minutes, [32:31] status, rest zero

  int    fail_count;
  int    pending;
  int    items_sent = 0;
  int    cycle_count = 0;
  int    ready_left = 0;
  bit    steady = 1'b0;
  byte_t text_q[$];

  duration_string_to_minutes #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  duration_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: runs of ready broken by random stalls.
  always @(negedge clk) begin
    logic nxt;
    int   stall;
    nxt = out_tready;
    if (steady) begin
      nxt = 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_tready) begin
      stall = pick_gap();
      if (stall > 0) begin
        nxt = 1'b0;
        ready_left = stall - 1;
      end else begin
        ready_left = $urandom_range(0, 15);
      end
    end else begin
      nxt = 1'b1;
      ready_left = $urandom_range(0, 15);
    end
    out_tready <= nxt;
  end

  // Starts and ends at a falling edge.
  task automatic send_item(input byte_t c, input logic last, input logic empty);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= c;
    in_tlast  <= last;
    in_tuser  <= empty;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input bit via_empty);
    bit use_empty;
    use_empty = via_empty || text_q.size() == 0;
    foreach (text_q[i])
      send_item(text_q[i], !use_empty && i == text_q.size() - 1, 1'b0);
    if (use_empty)
      send_item(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    text_q.delete();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Appends one character to the text being built.
  function automatic void add_byte(input byte_t b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Removes the final character of the text being built.
  function automatic void drop_last();
    if (text_q.size() != 0) text_q.delete(text_q.size() - 1);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(byte_t'(s[i]));
  endfunction

  function automatic void add_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      add_str("0");
    end else if (r < 60) begin
      add_str($sformatf("%0d", $urandom_range(1, 99)));
    end else if (r < 75) begin
      add_str($sformatf("%0d", $urandom_range(100, 99999)));
    end else if (r < 85) begin
      add_str($sformatf("0%0d", $urandom_range(0, 999)));
    end else if (r < 95) begin
      repeat ($urandom_range(9, 13)) add_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      // Values just inside and just past the saturation points.
      case ($urandom_range(0, 5))
        0: add_str("2147483647");
        1: add_str("2147483648");
        2: add_str("1491308");
        3: add_str("1491309");
        4: add_str("35791394");
        default: add_str("35791395");
      endcase
    end
  endfunction

  function automatic void add_form(input int form);
    if (form >= 3) begin
      add_field();
      add_byte(CH_DASH);
    end
    add_field();
    if (form == 1 || form == 2 || form >= 4) begin
      add_byte(CH_COLON);
      add_field();
    end
    if (form == 2 || form == 5) begin
      add_byte(CH_COLON);
      add_field();
    end
  endfunction

  function automatic byte_t blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  initial begin
    int    r;
    int    pos;
    int    text_no;
    bit    drained_once;
    string w;

    text_no = 0;
    drained_once = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed texts.
    send_item(8'hFF, 1'b1, 1'b1);
    add_str("UNLIMITED");
    send_text(1'b0);
    add_str("1-2:3:4");
    send_text(1'b0);
    add_str("9-\t");
    send_text(1'b0);
    add_str("::");
    send_text(1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    add_str("5");
    send_text(1'b1);

    while (items_sent < ITEM_TARGET) begin
      steady <= (text_no >= 40 && text_no < 70);
      if (!drained_once && items_sent >= ITEM_TARGET / 2) begin
        drained_once = 1'b1;
        drain_results();
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_form($urandom_range(0, 5));
      end else if (r < 58) begin
        // Day-only form: "D-" with nothing but blanks after it.
        add_field();
        add_byte(CH_DASH);
        repeat ($urandom_range(0, 3)) add_byte(blank_char());
      end else if (r < 64) begin
        w = $urandom_range(0, 1) ? "unlimited" : "UNLIMITED";
        add_str(w);
        pos = $urandom_range(0, 8);
        case ($urandom_range(0, 4))
          1: repeat ($urandom_range(1, 8)) drop_last();
          2: add_byte(byte_t'($urandom_range(0, 255)));
          3: text_q[pos] = text_q[pos] ^ 8'h20;
          4: text_q[pos] = byte_t'($urandom_range(0, 255));
          default: ;
        endcase
      end else if (r < 80) begin
        add_form($urandom_range(0, 5));
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 5))
          0: text_q[pos] = CH_COLON;
          1: text_q[pos] = CH_DASH;
          2: text_q[pos] = blank_char();
          3: text_q.insert(pos, CH_DASH);
          4: text_q[pos] = "a";
          default: text_q[pos] = byte_t'($urandom_range(0, 255));
        endcase
      end else if (r < 88) begin
        // More than three colon parts.
        add_form($urandom_range(0, 1) ? 2 : 5);
        add_byte(CH_COLON);
        add_field();
      end else if (r < 94) begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 3))
            0: add_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
            1: add_byte($urandom_range(0, 1) ? CH_COLON : CH_DASH);
            2: add_byte(blank_char());
            default: add_byte(byte_t'($urandom_range(0, 255)));
          endcase
        end
      end
      send_text($urandom_range(0, 99) < 15);
      text_no++;
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
